// ===== hw/rtl/dmaes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmaes_pkg: shared types and functions of the Davies-Meyer AES-128 hash
// Holds the S-box, the round helpers, the key-schedule step and the stage
// record that travels down the round pipeline.
// ----------------------------------------------------------------------------
package dmaes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned StageW    = $clog2(NumRounds + 1);

  typedef logic [127:0] block_t;

  // One pipeline slot: running state, current round key, original value.
  typedef struct packed {
    block_t state;
    block_t rkey;
    block_t value;
  } slot_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [StageW-1:0] r);
    logic [7:0] v;
    case (r)
      StageW'(1):  v = 8'h01;
      StageW'(2):  v = 8'h02;
      StageW'(3):  v = 8'h04;
      StageW'(4):  v = 8'h08;
      StageW'(5):  v = 8'h10;
      StageW'(6):  v = 8'h20;
      StageW'(7):  v = 8'h40;
      StageW'(8):  v = 8'h80;
      StageW'(9):  v = 8'h1b;
      StageW'(10): v = 8'h36;
      default:     v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits at bits 8i+7..8i.
  function automatic logic [7:0] byte_at(input block_t b, input int unsigned i);
    return b[8*i +: 8];
  endfunction

  // Next round key from the previous one.
  function automatic block_t key_step(input block_t k, input logic [StageW-1:0] r);
    block_t n;
    logic [31:0] t;
    t = {sbox(byte_at(k, 12)), sbox(byte_at(k, 15)), sbox(byte_at(k, 14)),
         sbox(byte_at(k, 13)) ^ rcon(r)};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns.
  function automatic block_t round_core(input block_t s, input logic last);
    block_t t, m;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = sbox(s[8*(r + 4*((c + r) % 4)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c) +: 8]   = a0 ^ all ^ xtime(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return last ? t : m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dmaes_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmaes_round: one AES-128 round stage with its key-schedule step
// Registered slot with a valid bit; advances when the downstream stage has room.
// ----------------------------------------------------------------------------
module dmaes_round
  import dmaes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [StageW-1:0] round_num,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire slot_t             in_slot,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output slot_t                  out_slot
);

  slot_t slot_next;
  block_t rk_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    rk_next         = key_step(in_slot.rkey, round_num);
    slot_next.state = round_core(in_slot.state, round_num == StageW'(NumRounds)) ^ rk_next;
    slot_next.rkey  = rk_next;
    slot_next.value = in_slot.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_slot <= slot_next;
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_slot))
    else $error("stalled round stage lost its word");
  a_value_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_slot.value == $past(in_slot.value))
    else $error("value did not follow its word");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word dropped");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/davies_meyer_aes128_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// davies_meyer_aes128_hash: Davies-Meyer hash over AES-128, key per word
// Channel | signals                                  | direction
// input   | valid, ready, key_hi/lo, value_hi/lo     | in
// output  | hash_valid, hash_ready, hash_hi/lo       | out
// One word per cycle while hash_ready is high; input whitening stage plus ten
// round stages, each with its own key-schedule step.
// Synchronous reset clears all stage valid bits; payload is not reset.
// A stall on the output backs up stage by stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module davies_meyer_aes128_hash
  import dmaes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [63:0] key_hi,
  input  wire logic [63:0] key_lo,
  input  wire logic [63:0] value_hi,
  input  wire logic [63:0] value_lo,
  output logic             hash_valid,
  input  wire logic        hash_ready,
  output logic [63:0]      hash_hi,
  output logic [63:0]      hash_lo
);

  logic  v   [NumRounds+1];
  logic  rdy [NumRounds+1];
  slot_t s   [NumRounds+1];

  // Stage 0: initial AddRoundKey.
  assign ready = !v[0] || rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (ready) begin
      v[0] <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) begin
      s[0].state <= {value_hi, value_lo} ^ {key_hi, key_lo};
      s[0].rkey  <= {key_hi, key_lo};
      s[0].value <= {value_hi, value_lo};
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    dmaes_round u_round (
      .clk      (clk),
      .rst      (rst),
      .round_num(StageW'(g)),
      .in_valid (v[g-1]),
      .in_ready (rdy[g-1]),
      .in_slot  (s[g-1]),
      .out_valid(v[g]),
      .out_ready(rdy[g]),
      .out_slot (s[g])
    );
  end

  assign rdy[NumRounds] = hash_ready;
  assign hash_valid     = v[NumRounds];
  assign hash_hi        = s[NumRounds].state[127:64] ^ s[NumRounds].value[127:64];
  assign hash_lo        = s[NumRounds].state[63:0] ^ s[NumRounds].value[63:0];

`ifndef ASSERT_OFF
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    v[0] && !rdy[0] |=> v[0] && $stable(s[0]))
    else $error("whitening stage lost its word");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    hash_valid && !hash_ready |=> hash_valid && $stable(hash_hi) && $stable(hash_lo))
    else $error("stalled hash word changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> ready)
    else $error("empty pipeline refused a word");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the Davies-Meyer AES-128 hash
// Drives key/value words through a valid/ready channel with random gaps and
// output stalls, predicts each hash with an independent AES-128 model and
// compares every returned word in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY    = 11;
  localparam int unsigned RANDOM_N   = 2000;
  localparam int unsigned STALL_MAX  = 2000;

  typedef struct {
    logic [63:0] key_hi, key_lo, value_hi, value_lo;
    logic        known;
    logic [63:0] hash_hi, hash_lo;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [63:0] key_hi = '0, key_lo = '0, value_hi = '0, value_lo = '0;
  logic        hash_valid;
  logic        hash_ready = 1'b0;
  logic [63:0] hash_hi, hash_lo;

  logic [127:0] hash_queue [$];
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  byte unsigned sbox_lut [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  davies_meyer_aes128_hash u_top (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .key_hi(key_hi), .key_lo(key_lo), .value_hi(value_hi), .value_lo(value_lo),
    .hash_valid(hash_valid), .hash_ready(hash_ready),
    .hash_hi(hash_hi), .hash_lo(hash_lo)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic byte unsigned gmul2(input byte unsigned x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block is bits 8i+7..8i; returns ciphertext XOR value.
  function automatic logic [127:0] dm_hash(input logic [127:0] key, input logic [127:0] value);
    byte unsigned rk [176];
    byte unsigned st [16];
    byte unsigned sr [16];
    byte unsigned w [4];
    byte unsigned rc;
    byte unsigned a0, a1, a2, a3, x;
    byte unsigned first;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[8*i +: 8];
      st[i] = value[8*i +: 8] ^ key[8*i +: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        first = w[0];
        w[0] = sbox_lut[w[1]] ^ rc;
        w[1] = sbox_lut[w[2]];
        w[2] = sbox_lut[w[3]];
        w[3] = sbox_lut[first];
        rc = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          sr[r+4*c] = sbox_lut[st[r + 4*((c+r)%4)]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          sr[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
          sr[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          sr[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          sr[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = sr[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) ct[8*i +: 8] = st[i];
    return ct ^ value;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Present one word and hold it until accepted; drop valid only for idle gaps.
  task automatic send_word(input logic [63:0] kh, input logic [63:0] kl,
                           input logic [63:0] vh, input logic [63:0] vl,
                           input logic known, input logic [127:0] want);
    logic [127:0] pred;
    if ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pred = dm_hash({kh, kl}, {vh, vl});
    if (known && pred !== want) begin
      report_mismatch("table_hi", pred[127:64], want[127:64]);
      report_mismatch("table_lo", pred[63:0], want[63:0]);
    end
    hash_queue.push_back(known ? want : pred);
    valid    <= 1'b1;
    key_hi   <= kh;
    key_lo   <= kl;
    value_hi <= vh;
    value_lo <= vl;
    do @(posedge clk); while (!ready);
  endtask

  // Receiver side: stall at random, check each word against the oldest hash.
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if (hash_valid && hash_ready) begin
        if (hash_queue.size() == 0) begin
          report_mismatch("unexpected hash_lo", hash_lo, 64'h0);
        end else begin
          want = hash_queue.pop_front();
          if (hash_hi !== want[127:64]) report_mismatch("hash_hi", hash_hi, want[127:64]);
          if (hash_lo !== want[63:0])   report_mismatch("hash_lo", hash_lo, want[63:0]);
        end
      end
      hash_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (valid && ready) || (hash_valid && hash_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    vec_t table_rows [$];
    vec_t row;
    logic [63:0] kh, kl, vh, vl;
    int unsigned pick;
    // FIPS-197 appendix C.1 vector, bytes reversed into the little-endian halves.
    row = '{64'h0f0e0d0c0b0a0908, 64'h0706050403020100, 64'hffeeddccbbaa9988,
            64'h7766554433221100, 1'b1, 64'h0, 64'h0};
    {row.hash_hi, row.hash_lo} = {64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469} ^
                                 {row.value_hi, row.value_lo};
    table_rows.push_back(row);
    table_rows.push_back('{64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0});
    table_rows.push_back('{'1, '1, '1, '1, 1'b0, 64'h0, 64'h0});
    table_rows.push_back('{64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0});
    table_rows.push_back('{'1, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0});
    table_rows.push_back('{64'h8000000000000000, 64'h1, 64'h8000000000000000, 64'h1,
                           1'b0, 64'h0, 64'h0});
    table_rows.push_back('{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                           64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0});
    table_rows.push_back('{64'h0123456789abcdef, 64'hfedcba9876543210,
                           64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    hash_ready <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i])
      send_word(table_rows[i].key_hi, table_rows[i].key_lo, table_rows[i].value_hi,
                table_rows[i].value_lo, table_rows[i].known,
                {table_rows[i].hash_hi, table_rows[i].hash_lo});

    for (int n = 0; n < RANDOM_N; n++) begin
      if (n == 0)                 begin send_idle_pct = 34; recv_idle_pct = 48; end
      else if (n == RANDOM_N/3)   begin send_idle_pct = 48; recv_idle_pct = 34; end
      else if (n == 2*RANDOM_N/3) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      kh = rand64(); kl = rand64(); vh = rand64(); vl = rand64();
      // Occasionally force sparse or dense halves and a repeated key.
      pick = $urandom_range(15);
      if (pick == 0) {kh, kl} = {64'h0, 64'h0};
      if (pick == 1) {vh, vl} = {'1, '1};
      if (pick == 2) vh = 64'h0;
      if (pick == 3) kl = '1;
      send_word(kh, kl, vh, vl, 1'b0, '0);
    end
    valid <= 1'b0;

    while (hash_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
